// ===== hw/rtl/bra_pkg.sv =====
// Shared types and constants of the bitmap range allocator.
package bra_pkg;

  localparam int unsigned MAP_BITS_DEF = 1024;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned WORD_SEL     = 5;
  localparam logic [WORD_BITS-1:0] WORD_ONES = 32'hffffffff;

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_FIND = 2'd0,
    OP_FILL = 2'd1,
    OP_DONE = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        fill_val;
    status_e     status;
    logic [9:0]  start;
    logic [10:0] len;
    logic [10:0] align;
  } cmd_t;

endpackage

// ===== hw/rtl/bra_ram.sv =====
// Generic single write, single registered read RAM.
module bra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bra_front.sv =====
// Request intake: classifies each request and queues it for the engine.
module bra_front #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [1:0]    kind_i,
  input  logic [9:0]    start_index_i,
  input  logic [10:0]   run_length_i,
  input  logic [10:0]   alignment_i,
  input  logic          accept_en_i,
  output logic          cmd_valid_o,
  output bra_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import bra_pkg::*;

  localparam int unsigned LW = $clog2(MAP_BITS + 2048) + 1;
  localparam logic [LW-1:0] MAP_L = LW'(MAP_BITS);

  cmd_t        cls;
  logic [LW-1:0] sum;
  cmd_t        q_mem [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign sum = LW'(start_index_i) + LW'(run_length_i);

  always_comb begin
    cls          = '0;
    cls.start    = start_index_i;
    cls.len      = run_length_i;
    cls.align    = (alignment_i == 11'd0) ? 11'd1 : alignment_i;
    cls.fill_val = (kind_i == KIND_SET);
    cls.status   = ST_OK;
    cls.op       = OP_DONE;
    case (kind_i)
      KIND_FIND: begin
        if (run_length_i == 11'd0) begin
          cls.op = OP_DONE;
        end else if (LW'(run_length_i) > MAP_L) begin
          cls.status = ST_NOSPACE;
        end else begin
          cls.op = OP_FIND;
        end
      end
      KIND_SET, KIND_CLEAR: begin
        if (sum > MAP_L) begin
          cls.status = ST_RANGE;
        end else if (run_length_i != 11'd0) begin
          cls.op = OP_FILL;
        end
      end
      default: begin
        cls.status = ST_RANGE;
      end
    endcase
  end

  assign full_o      = (cnt_q == 2'd2) || !accept_en_i;
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hw/rtl/bra_back.sv =====
// Engine: map clearing pass, range fills and word-by-word first-fit scan.
module bra_back #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  bra_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          init_done_o,
  output logic          res_valid_o,
  output logic [1:0]    res_status_o,
  output logic [9:0]    res_found_o,
  input  logic          res_pop_i
);
  import bra_pkg::*;

  localparam int unsigned NW = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CW = $clog2(MAP_BITS + 2048) + 1;
  localparam int unsigned NCW = $clog2(CW + 1);
  localparam logic [CW-1:0] MAP_C = CW'(MAP_BITS);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_FRD  = 8'b0000_0100,
    S_FWR  = 8'b0000_1000,
    S_SRD  = 8'b0001_0000,
    S_SCHK = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_MUL  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   cur_q, cur_d, end_q, end_d, cand_q, cand_d, dq_q, dq_d;
  logic [10:0]     len_q, len_d, align_q, align_d, rq_q, rq_d;
  logic [NCW-1:0]  cnt_q, cnt_d;
  logic            fill_q, fill_d;
  logic            res_valid_q, res_valid_d;
  status_e         res_status_q, res_status_d;
  logic [9:0]      res_found_q, res_found_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 last_word;
  logic [4:0]           lo, hi, lo_idx;
  logic [WORD_BITS-1:0] mask, hit;
  logic [CW-1:0]        sum, next_word, busy_nx;
  logic [11:0]          trial;
  logic [CW+10:0]       prod;

  bra_ram #(.WIDTH(WORD_BITS), .DEPTH(NW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_word = (cur_q[CW-1:WORD_SEL] == end_q[CW-1:WORD_SEL]);
  assign lo        = cur_q[4:0];
  assign hi        = last_word ? end_q[4:0] : 5'd31;
  assign mask      = (WORD_ONES << lo) & (WORD_ONES >> (5'd31 - hi));
  assign hit       = ram_rdata & mask;
  assign sum       = cand_q + CW'(len_q);
  assign next_word = {cur_q[CW-1:WORD_SEL] + 1'b1, 5'd0};
  assign busy_nx   = {cur_q[CW-1:WORD_SEL], lo_idx} + 1'b1;
  assign trial     = {rq_q, dq_q[CW-1]};
  assign prod      = dq_q * align_q;

  always_comb begin
    lo_idx = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) lo_idx = 5'(i);
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    end_d        = end_q;
    cand_d       = cand_q;
    dq_d         = dq_q;
    rq_d         = rq_q;
    len_d        = len_q;
    align_d      = align_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    res_valid_d  = res_valid_q && !res_pop_i;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur_q[WORD_SEL +: AW];
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = cur_q[WORD_SEL +: AW];
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == AW'(NW - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_pop_o = 1'b1;
          len_d     = cmd_i.len;
          align_d   = cmd_i.align;
          fill_d    = cmd_i.fill_val;
          case (cmd_i.op)
            OP_FILL: begin
              cur_d   = CW'(cmd_i.start);
              end_d   = CW'(cmd_i.start) + CW'(cmd_i.len) - 1'b1;
              state_d = S_FRD;
            end
            OP_FIND: begin
              cur_d   = '0;
              cand_d  = '0;
              state_d = S_SRD;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = cmd_i.status;
              res_found_d  = '0;
            end
          endcase
        end
      end
      S_FRD: begin
        ram_re  = 1'b1;
        state_d = S_FWR;
      end
      S_FWR: begin
        ram_we    = 1'b1;
        ram_wdata = fill_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
        if (last_word) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_OK;
          res_found_d  = '0;
          state_d      = S_IDLE;
        end else begin
          cur_d   = next_word;
          state_d = S_FRD;
        end
      end
      S_SRD: begin
        if (sum > MAP_C) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_NOSPACE;
          res_found_d  = '0;
          state_d      = S_IDLE;
        end else begin
          end_d   = sum - 1'b1;
          ram_re  = 1'b1;
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (hit == '0) begin
          if (last_word) begin
            res_valid_d  = 1'b1;
            res_status_d = ST_OK;
            res_found_d  = cand_q[9:0];
            state_d      = S_IDLE;
          end else begin
            cur_d   = next_word;
            state_d = S_SRD;
          end
        end else if (align_q == 11'd1) begin
          cand_d  = busy_nx;
          cur_d   = busy_nx;
          state_d = S_SRD;
        end else begin
          dq_d    = busy_nx + CW'(align_q) - 1'b1;
          rq_d    = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, align_q}) begin
          rq_d = 11'(trial - {1'b0, align_q});
          dq_d = {dq_q[CW-2:0], 1'b1};
        end else begin
          rq_d = trial[10:0];
          dq_d = {dq_q[CW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == NCW'(CW - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cand_d  = prod[CW-1:0];
        cur_d   = prod[CW-1:0];
        state_d = S_SRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    end_q        <= end_d;
    cand_q       <= cand_d;
    dq_q         <= dq_d;
    rq_q         <= rq_d;
    len_q        <= len_d;
    align_q      <= align_d;
    cnt_q        <= cnt_d;
    fill_q       <= fill_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
  end

  assign init_done_o  = (state_q != S_CLR);
  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_found_o  = res_found_q;

endmodule

// ===== hw/rtl/bitmap_range_allocator.sv =====
// Top level of the bitmap range allocator.
// After reset the map is cleared one 32-bit word per cycle, ceil(MAP_BITS/32) words (32 at
// 1024 bits), with full high. A request is classified as it is accepted and queued for the
// engine; zero-length, oversized and out-of-range requests then complete with no map access.
// Set and clear read, then masked-write, each map word touched (the map RAM read is
// registered). Find reads and checks the map word by word from the current candidate and,
// for each busy bit that moves the candidate under an alignment other than one, takes an
// alignment step (serial divide and a multiply). Two requests queue ahead of the engine and
// one result waits on the output.
module bitmap_range_allocator #(
  parameter int unsigned MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  start_index_i,
  input  logic [10:0] run_length_i,
  input  logic [10:0] alignment_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [9:0]  found_start_o
);
  import bra_pkg::*;

  logic cmd_valid, cmd_pop, init_done, res_valid;
  cmd_t cmd;

  bra_front #(.MAP_BITS(MAP_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .start_index_i (start_index_i),
    .run_length_i  (run_length_i),
    .alignment_i   (alignment_i),
    .accept_en_i   (init_done),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bra_back #(.MAP_BITS(MAP_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .init_done_o  (init_done),
    .res_valid_o  (res_valid),
    .res_status_o (status_o),
    .res_found_o  (found_start_o),
    .res_pop_i    (pop)
  );

  assign empty = !res_valid;

endmodule

// ===== hw/rtl/bra_checker.sv =====
// Port-level checks on the bitmap range allocator, bound to its top level.
module bra_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status_o,
  input logic [9:0] found_start_o
);
  import bra_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_OK || status_o == ST_NOSPACE || status_o == ST_RANGE))
    else $error("result beat carries an unused status code");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (found_start_o == 10'd0))
    else $error("failed result beat carries a non-zero start");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(found_start_o)))
    else $error("waiting result beat changed or vanished");

  a_no_result_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> empty)
    else $error("result beat shown straight after reset");

endmodule

bind bitmap_range_allocator bra_checker u_bra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .status_o      (status_o),
  .found_start_o (found_start_o)
);

// ===== tb/bitmap_range_allocator_tb.sv =====
// Testbench for the bitmap range allocator: directed and random requests against a predictor.
module bitmap_range_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bra_pkg::*;

  localparam int MAP = MAP_BITS_DEF;
  localparam int WATCH_LIMIT = 60000;
  localparam int CALM_TAIL = 60;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic        drain;
    logic [1:0]  kind;
    logic [9:0]  start;
    logic [10:0] len;
    logic [10:0] align;
  } req_t;

  typedef struct {
    status_e    status;
    logic [9:0] found;
  } alloc_res_t;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [1:0]  kind_i;
  logic [9:0]  start_index_i;
  logic [10:0] run_length_i, alignment_i;
  logic [1:0]  status_o;
  logic [9:0]  found_start_o;

  req_t       pending_reqs[$];
  alloc_res_t expected_res[$];
  logic [MAP-1:0] busy_bits;
  int  send_gap, pop_gap, idle_cycles;
  bit  failed;

  bitmap_range_allocator uut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .start_index_i, .run_length_i,
    .alignment_i, .empty, .pop, .status_o, .found_start_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic alloc_res_t first_fit(int len, int align);
    alloc_res_t r;
    int cand;
    r.status = ST_OK;
    r.found  = '0;
    if (len == 0) return r;
    if (align == 0) align = 1;
    if (len > MAP) begin
      r.status = ST_NOSPACE;
      return r;
    end
    cand = 0;
    for (int i = 0; i < MAP; i++) begin
      if (busy_bits[i]) begin
        cand = ((i + 1 + align - 1) / align) * align;
      end else if (cand <= i && i - cand + 1 >= len) begin
        r.found = cand[9:0];
        return r;
      end
    end
    r.status = ST_NOSPACE;
    return r;
  endfunction

  function automatic alloc_res_t apply_req(logic [1:0] kind, int start, int len, int align);
    alloc_res_t r;
    r.status = ST_OK;
    r.found  = '0;
    if (kind == KIND_FIND) begin
      r = first_fit(len, align);
    end else if (kind == KIND_SET || kind == KIND_CLEAR) begin
      if (start + len > MAP) begin
        r.status = ST_RANGE;
      end else begin
        for (int i = start; i < start + len; i++) busy_bits[i] = (kind == KIND_SET);
      end
    end else begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] k, int s, int l, int a);
    req_t q;
    q.drain = 0;
    q.kind  = k;
    q.start = s[9:0];
    q.len   = l[10:0];
    q.align = a[10:0];
    return q;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int p;
    p = $urandom_range(0, 99);
    q = mk(KIND_FIND, $urandom_range(0, 1023), $urandom_range(0, 40),
           1 << $urandom_range(0, 10));
    if (p < 35) q.kind = KIND_SET;
    else if (p < 52) q.kind = KIND_CLEAR;
    else if (p < 56) q.kind = KIND_UNUSED;
    if ($urandom_range(0, 19) == 0) q.len = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 9) == 0) q.align = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 49) == 0) q = mk(KIND_CLEAR, 0, MAP, 1);
    return q;
  endfunction

  initial begin
    req_t d;
    d.drain = 1;
    pending_reqs.push_back(mk(KIND_FIND, 0, 0, 1));
    pending_reqs.push_back(mk(KIND_FIND, 1023, 1024, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 1025, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 2047, 2047));
    pending_reqs.push_back(mk(KIND_FIND, 0, 5, 0));
    pending_reqs.push_back(mk(KIND_SET, 0, 3, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 1, 1024));
    pending_reqs.push_back(mk(KIND_FIND, 0, 1, 2047));
    pending_reqs.push_back(mk(KIND_FIND, 0, 4, 3));
    pending_reqs.push_back(mk(KIND_SET, 1023, 2, 1));
    pending_reqs.push_back(mk(KIND_SET, 1023, 1, 1));
    pending_reqs.push_back(mk(KIND_CLEAR, 1023, 0, 1));
    pending_reqs.push_back(mk(KIND_SET, 0, 2047, 1));
    pending_reqs.push_back(mk(KIND_SET, 0, MAP, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 1, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 0, 7));
    pending_reqs.push_back(mk(KIND_UNUSED, 1023, 2047, 2047));
    pending_reqs.push_back(mk(KIND_CLEAR, 512, 512, 1));
    pending_reqs.push_back(mk(KIND_FIND, 0, 512, 512));
    pending_reqs.push_back(mk(KIND_FIND, 0, 100, 5));
    pending_reqs.push_back(mk(KIND_CLEAR, 0, MAP, 1));
    pending_reqs.push_back(d);
    for (int n = 0; n < 500; n++) begin
      pending_reqs.push_back(rand_req());
      if (n == 250) pending_reqs.push_back(d);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      kind_i        <= '0;
      start_index_i <= '0;
      run_length_i  <= '0;
      alignment_i   <= '0;
      send_gap      <= 0;
      busy_bits     <= '0;
    end else begin
      if (push && !full)
        expected_res.push_back(apply_req(kind_i, int'(start_index_i), int'(run_length_i),
                                         int'(alignment_i)));
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push     <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          push <= 1'b0;
        end else if (pending_reqs[0].drain) begin
          push <= 1'b0;
          if (expected_res.size() == 0) void'(pending_reqs.pop_front());
        end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 15);
          push     <= 1'b0;
        end else begin
          req_t q;
          q = pending_reqs.pop_front();
          push          <= 1'b1;
          kind_i        <= q.kind;
          start_index_i <= q.start;
          run_length_i  <= q.len;
          alignment_i   <= q.align;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result beat: status %0d found_start %0d", status_o, found_start_o);
          failed = 1;
        end else begin
          alloc_res_t e;
          e = expected_res.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            failed = 1;
          end
          if (found_start_o !== e.found) begin
            $error("found_start: expected %0d, got %0d", e.found, found_start_o);
            failed = 1;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop     <= 1'b0;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        pop_gap <= $urandom_range(0, 15);
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    failed      = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !push && expected_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
